### rtl/o2_heater_actuator_test_sequencer_macros.svh
// Assertion macros for the heater actuator test sequencer.
// No dependencies; included by files that carry concurrent checks.
`ifndef O2_HEATER_ACTUATOR_TEST_SEQUENCER_MACROS_SVH
`define O2_HEATER_ACTUATOR_TEST_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define O2HT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("o2ht assertion failed");
`define O2HT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("o2ht assertion failed");
`else
`define O2HT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define O2HT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/o2ht_pkg.sv
// Shared types, limits and register codes for the heater actuator test sequencer.
// No dependencies.
package o2ht_pkg;

	localparam int TOTAL_W = 17;
	localparam int PHASE_W = 9;
	localparam int CODE_W  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [TOTAL_W-1:0] TOTAL_LIMIT = 17'd120000;
	localparam logic [PHASE_W-1:0] PHASE_LIMIT = 9'd400;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_OFF  = 2'd1,
		MODE_ON   = 2'd2,
		MODE_END  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEST_CODE      = 3'd0,
		REG_TOTAL_TICKS    = 3'd1,
		REG_OFF_TICKS      = 3'd2,
		REG_ON_TICKS       = 3'd3,
		REG_END_HOLD_TICKS = 3'd4
	} cfg_idx_t;

	// register values are kept already clamped to their limits
	typedef struct packed {
		logic [CODE_W-1:0]  test_code;
		logic [TOTAL_W-1:0] total_ticks;
		logic [PHASE_W-1:0] off_ticks;
		logic [PHASE_W-1:0] on_ticks;
		logic [TOTAL_W-1:0] end_hold_ticks;
	} cfg_t;

	typedef struct packed {
		mode_t              mode;
		logic [TOTAL_W-1:0] total;
		logic [PHASE_W-1:0] phase;
		logic [TOTAL_W-1:0] hold;
	} res_t;

	function automatic logic [TOTAL_W-1:0] clamp_total(input logic [TOTAL_W-1:0] v);
		return (v < TOTAL_LIMIT) ? v : TOTAL_LIMIT;
	endfunction

	function automatic logic [PHASE_W-1:0] clamp_phase(input logic [PHASE_W-1:0] v);
		return (v < PHASE_LIMIT) ? v : PHASE_LIMIT;
	endfunction

endpackage

### rtl/o2ht_cfg.sv
// Configuration register file; values are clamped to their limits on write.
// Depends on o2ht_pkg.
module o2ht_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [o2ht_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [o2ht_pkg::CFG_DATA_W-1:0]     cfg_data,
	output o2ht_pkg::cfg_t                      cfg
);

	o2ht_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (o2ht_pkg::cfg_idx_t'(cfg_index))
				o2ht_pkg::REG_TEST_CODE: begin
					cfg_q.test_code <= cfg_data[o2ht_pkg::CODE_W-1:0];
				end
				o2ht_pkg::REG_TOTAL_TICKS: begin
					cfg_q.total_ticks <= o2ht_pkg::clamp_total(cfg_data);
				end
				o2ht_pkg::REG_OFF_TICKS: begin
					cfg_q.off_ticks <= o2ht_pkg::clamp_phase(cfg_data[o2ht_pkg::PHASE_W-1:0]);
				end
				o2ht_pkg::REG_ON_TICKS: begin
					cfg_q.on_ticks <= o2ht_pkg::clamp_phase(cfg_data[o2ht_pkg::PHASE_W-1:0]);
				end
				o2ht_pkg::REG_END_HOLD_TICKS: begin
					cfg_q.end_hold_ticks <= o2ht_pkg::clamp_total(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/o2ht_core.sv
// Test sequencer state machine and its phase, total and hold timers.
// Depends on o2ht_pkg; advances one tick when step is high.
module o2ht_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic                            service_enable,
	input  logic [o2ht_pkg::CODE_W-1:0]     requested_code,
	input  o2ht_pkg::cfg_t                  cfg,
	output o2ht_pkg::res_t                  nxt
);

	o2ht_pkg::mode_t                 mode_q;
	logic [o2ht_pkg::TOTAL_W-1:0]    total_q;
	logic [o2ht_pkg::PHASE_W-1:0]    phase_q;
	logic [o2ht_pkg::TOTAL_W-1:0]    hold_q;

	o2ht_pkg::mode_t                 mode_d;
	logic [o2ht_pkg::TOTAL_W-1:0]    total_d;
	logic [o2ht_pkg::PHASE_W-1:0]    phase_d;
	logic [o2ht_pkg::TOTAL_W-1:0]    hold_d;

	logic enable;
	logic total_end;
	logic phase_end;
	logic hold_zero;

	assign enable    = service_enable && (requested_code == cfg.test_code);
	assign total_end = (total_q <= o2ht_pkg::TOTAL_W'(1));
	assign phase_end = (phase_q <= o2ht_pkg::PHASE_W'(1));
	assign hold_zero = (hold_q == '0);

	// next state
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			o2ht_pkg::MODE_IDLE: begin
				if (enable) mode_d = o2ht_pkg::MODE_OFF;
			end
			o2ht_pkg::MODE_OFF, o2ht_pkg::MODE_ON: begin
				if (!enable) begin
					mode_d = o2ht_pkg::MODE_IDLE;
				end else if (total_end) begin
					mode_d = o2ht_pkg::MODE_END;
				end else if (phase_end) begin
					mode_d = (mode_q == o2ht_pkg::MODE_OFF) ? o2ht_pkg::MODE_ON
						: o2ht_pkg::MODE_OFF;
				end
			end
			o2ht_pkg::MODE_END: begin
				if (enable && hold_zero) mode_d = o2ht_pkg::MODE_IDLE;
			end
			default: mode_d = o2ht_pkg::MODE_IDLE;
		endcase
	end

	// timers; counts never exceed their limits, so idle clamping is implicit
	always_comb begin
		total_d = total_q;
		phase_d = phase_q;
		hold_d  = hold_q;
		unique case (mode_q)
			o2ht_pkg::MODE_IDLE: begin
				if (enable) begin
					total_d = cfg.total_ticks;
					phase_d = cfg.off_ticks;
				end
			end
			o2ht_pkg::MODE_OFF, o2ht_pkg::MODE_ON: begin
				if (enable) begin
					if (total_end) begin
						hold_d = cfg.end_hold_ticks;
					end else begin
						total_d = total_q - o2ht_pkg::TOTAL_W'(1);
						if (phase_end) begin
							phase_d = (mode_q == o2ht_pkg::MODE_OFF) ? cfg.on_ticks
								: cfg.off_ticks;
						end else begin
							phase_d = phase_q - o2ht_pkg::PHASE_W'(1);
						end
					end
				end
			end
			o2ht_pkg::MODE_END: begin
				if (!hold_zero && !enable) begin
					hold_d = hold_q - o2ht_pkg::TOTAL_W'(1);
				end else if (!hold_zero) begin
					hold_d = hold_q - o2ht_pkg::TOTAL_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= o2ht_pkg::MODE_IDLE;
			total_q <= '0;
			phase_q <= '0;
			hold_q  <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			total_q <= total_d;
			phase_q <= phase_d;
			hold_q  <= hold_d;
		end
	end

	assign nxt.mode  = mode_d;
	assign nxt.total = total_d;
	assign nxt.phase = phase_d;
	assign nxt.hold  = hold_d;

endmodule

### rtl/o2_heater_actuator_test_sequencer.sv
// Top level of the downstream oxygen sensor heater actuator test sequencer.
// Depends on o2ht_pkg, o2ht_cfg, o2ht_core and the assertion macro header.
//
// Each accepted input word is one tick of the test sequencer and yields exactly one
// result word. A word is registered on entry, stepped through the state machine from that
// register and lands in the output register, so a result is offered once the output
// register is free, and one word is taken every cycle while the consumer does not stall;
// the single state update per tick sets that rate. Input stall rises only while the
// input register is full and the output register holds a word that the consumer stalls.
// Configuration writes are always ready and take effect on the next tick; write them
// only while no word is in flight.
`include "o2_heater_actuator_test_sequencer_macros.svh"

module o2_heater_actuator_test_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [o2ht_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [o2ht_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                service_enable,
	input  logic [o2ht_pkg::CODE_W-1:0]         requested_code,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          test_state,
	output logic                                heater_cmd,
	output logic                                relay_cmd,
	output logic                                test_done,
	output logic [o2ht_pkg::TOTAL_W-1:0]        total_left,
	output logic [o2ht_pkg::PHASE_W-1:0]        phase_left,
	output logic [o2ht_pkg::TOTAL_W-1:0]        hold_left
);

	o2ht_pkg::cfg_t cfg;
	o2ht_pkg::res_t nxt;
	o2ht_pkg::res_t res_q;

	logic                            valid_s1;
	logic                            enable_s1;
	logic [o2ht_pkg::CODE_W-1:0]     code_s1;
	logic                            out_valid_q;
	logic                            advance;
	logic                            in_take;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign in_take   = in_valid && !in_stall;

	o2ht_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	o2ht_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.service_enable (enable_s1),
		.requested_code (code_s1),
		.cfg            (cfg),
		.nxt            (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			enable_s1 <= service_enable;
			code_s1   <= requested_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= nxt;
	end

	assign out_valid  = out_valid_q;
	assign test_state = res_q.mode;
	assign heater_cmd = (res_q.mode == o2ht_pkg::MODE_ON);
	assign relay_cmd  = (res_q.mode == o2ht_pkg::MODE_ON);
	assign test_done  = (res_q.mode == o2ht_pkg::MODE_END);
	assign total_left = res_q.total;
	assign phase_left = res_q.phase;
	assign hold_left  = res_q.hold;

	`O2HT_ASSERT_NXT(a_take_fills_s1, clk, arst_n, in_take, valid_s1)
	`O2HT_ASSERT_NXT(a_advance_fills_out, clk, arst_n, advance, out_valid_q)
	`O2HT_ASSERT_IMP(a_phase_in_range, clk, arst_n, out_valid_q, res_q.phase <= o2ht_pkg::PHASE_LIMIT)
	`O2HT_ASSERT_IMP(a_total_in_range, clk, arst_n, out_valid_q, res_q.total <= o2ht_pkg::TOTAL_LIMIT)
	`O2HT_ASSERT_IMP(a_hold_in_range, clk, arst_n, out_valid_q, res_q.hold <= o2ht_pkg::TOTAL_LIMIT)

endmodule
